/* hdl/cdr_pkg.sv */
// Shared types and constants for the container deframer / reassembler.
// Used by the channel interfaces, the front, queue, back, top level and checker.
// No dependencies.
package cdr_pkg;

  // Default reassembly buffer size in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  // Largest packet, header plus payload, that is accepted
  localparam int unsigned MAX_PACKET_BYTES = 256;

  // Header lengths of first and subsequent containers
  localparam logic [8:0] HDR_LEN_FIRST = 9'd6;
  localparam logic [8:0] HDR_LEN_OTHER = 9'd4;
  // Position of the flags byte in the header
  localparam logic [8:0] FLAGS_POS = 9'd2;

  // Token queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Result field widths
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned MLEN_W   = 13;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST   = 2'd0,
    CFG_SUBSEQ  = 2'd1,
    CFG_CONTROL = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_MORE      = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_SEQ_ERR   = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_IGNORED   = 3'd6
  } status_t;

  // Type codes from the configuration registers
  typedef struct packed {
    logic [1:0] first_code;
    logic [1:0] subseq_code;
    logic [1:0] control_code;
  } cfg_t;

  // One classified word from the front, with the packet header as it stands
  typedef struct packed {
    logic [7:0]  data;      // raw byte
    logic        last;      // byte ends the packet
    logic        pay;       // byte is inside the declared payload
    logic [7:0]  idx;       // payload index of the byte
    logic        hdr_done;  // header completes with this byte
    logic        whole;     // packet is complete and in size (valid with last)
    logic        fits;      // header plus payload within the size limit
    logic [1:0]  kind;
    logic [7:0]  trans;
    logic [7:0]  seq;
    logic [15:0] total;
    logic [7:0]  count;
    logic [3:0]  cmd;
  } tok_t;

endpackage

/* hdl/cdr_chan_if.sv */
// Valid/ready channel interfaces for the container deframer / reassembler.
// Depends on cdr_pkg for field widths.
interface cdr_in_if import cdr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, byte_value, last_byte, input ready);
  modport sink   (input valid, byte_value, last_byte, output ready);
endinterface

interface cdr_out_if import cdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                write_valid;
  logic [OFFSET_W-1:0] write_offset;
  logic [7:0]          write_data;
  logic [2:0]          end_status;
  logic [MLEN_W-1:0]   message_length;
  logic [3:0]          control_command;

  modport source (output valid, write_valid, write_offset, write_data, end_status,
                  message_length, control_command, input ready);
  modport sink   (input valid, write_valid, write_offset, write_data, end_status,
                  message_length, control_command, output ready);
endinterface

/* hdl/cdr_front.sv */
// Front end: accepts packet bytes, parses the header and classifies each word.
// Depends on cdr_pkg and cdr_in_if; feeds cdr_queue.
module cdr_front import cdr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  cdr_in_if.sink        in_ch,
  input  logic          q_ready,
  output logic          push,
  output tok_t          tok
);

  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  trans_r, trans_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic [15:0] total_r, total_nxt;
  logic [7:0]  count_r, count_nxt;

  logic [8:0]  hl, hl_new, pay_off;
  logic        pay, hdr_done, fits, whole;
  logic [7:0]  idx;
  logic [7:0]  b;

  assign b         = in_ch.byte_value;
  assign in_ch.ready = q_ready;
  assign push      = in_ch.valid && q_ready;

  // Header length follows the type seen so far
  assign hl      = (kind_r == cfg.first_code) ? HDR_LEN_FIRST : HDR_LEN_OTHER;
  assign pay_off = pos_r - hl;

  // Header parse and payload tracking
  always_comb begin
    pos_nxt   = pos_r;
    trans_nxt = trans_r;
    seq_nxt   = seq_r;
    kind_nxt  = kind_r;
    cmd_nxt   = cmd_r;
    total_nxt = total_r;
    count_nxt = count_r;
    pay       = 1'b0;
    idx       = '0;
    hdr_done  = 1'b0;
    if (pos_r < 9'd3 || pos_r < hl) begin
      priority if (pos_r == 9'd0) begin
        trans_nxt = b;
      end else if (pos_r == 9'd1) begin
        seq_nxt = b;
      end else if (pos_r == FLAGS_POS) begin
        kind_nxt = b[7:6];
        cmd_nxt  = b[5:2];
      end else if (hl == HDR_LEN_FIRST) begin
        priority if (pos_r == 9'd3) begin
          total_nxt = {8'd0, b};
        end else if (pos_r == 9'd4) begin
          total_nxt = {b, total_r[7:0]};
        end else begin
          count_nxt = b;
        end
      end else begin
        count_nxt = b;
      end
      pos_nxt  = pos_r + 9'd1;
      hdr_done = (pos_r >= 9'd3) && (pos_r + 9'd1 == hl);
    end else if (pay_off < {1'b0, count_r}) begin
      // payload byte; trailing bytes past the payload fall through
      pay     = 1'b1;
      idx     = pay_off[7:0];
      pos_nxt = pos_r + 9'd1;
    end
  end

  // Size and completeness seen after this byte
  assign hl_new = (kind_nxt == cfg.first_code) ? HDR_LEN_FIRST : HDR_LEN_OTHER;
  assign fits   = (hl_new + {1'b0, count_nxt}) <= 9'(MAX_PACKET_BYTES);
  assign whole  = (pos_nxt >= 9'd3) && (pos_nxt >= hl_new) &&
                  ((pos_nxt - hl_new) == {1'b0, count_nxt}) && fits;

  always_comb begin
    tok.data     = b;
    tok.last     = in_ch.last_byte;
    tok.pay      = pay;
    tok.idx      = idx;
    tok.hdr_done = hdr_done;
    tok.whole    = whole;
    tok.fits     = fits;
    tok.kind     = kind_nxt;
    tok.trans    = trans_nxt;
    tok.seq      = seq_nxt;
    tok.total    = total_nxt;
    tok.count    = count_nxt;
    tok.cmd      = cmd_nxt;
  end

  // Packet state; cleared at the end of each packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      trans_r <= '0;
      seq_r   <= '0;
      kind_r  <= '0;
      cmd_r   <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (push) begin
      if (in_ch.last_byte) begin
        pos_r   <= '0;
        trans_r <= '0;
        seq_r   <= '0;
        kind_r  <= '0;
        cmd_r   <= '0;
        total_r <= '0;
        count_r <= '0;
      end else begin
        pos_r   <= pos_nxt;
        trans_r <= trans_nxt;
        seq_r   <= seq_nxt;
        kind_r  <= kind_nxt;
        cmd_r   <= cmd_nxt;
        total_r <= total_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

/* hdl/cdr_queue.sv */
// Short word queue between the front and the back.
// Depends on cdr_pkg for the word type and depth.
module cdr_queue import cdr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_data,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output tok_t pop_data
);

  tok_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   fill_r;

  assign push_ready = (fill_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      priority if (push && !pop) begin
        fill_r <= fill_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

/* hdl/cdr_back.sv */
// Back end: reassembly state, staged buffer writes and end-of-packet status.
// Depends on cdr_pkg and cdr_out_if; drains cdr_queue.
module cdr_back import cdr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  tok_t     tok,
  output logic     q_pop,
  cdr_out_if.source out_ch
);

  localparam int unsigned RC_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SUM_W = ((RC_W > OFFSET_W) ? RC_W : OFFSET_W) + 1;
  localparam int unsigned CMP_W = 17;
  localparam logic [CMP_W-1:0] BUF_K = CMP_W'(BUFFER_BYTES);

  // Reassembly state
  logic            pa_r, pa_nxt;
  logic            busy_r, busy_nxt;
  logic [7:0]      at_r, at_nxt;
  logic [15:0]     atot_r, atot_nxt;
  logic [7:0]      ns_r, ns_nxt;
  logic [RC_W-1:0] rc_r, rc_nxt;

  // Output register
  logic                ov_r;
  logic                wv_r;
  logic [OFFSET_W-1:0] wo_r;
  logic [7:0]          wd_r;
  status_t             st_r;
  logic [MLEN_W-1:0]   ml_r;
  logic [3:0]          cmd_r;

  logic                is_first, is_sub, is_ctrl, sub_ok, pred;
  logic [CMP_W-1:0]    rc_sum, tot_ext;
  logic [7:0]          ns_inc;
  logic [SUM_W-1:0]    base, wsum, ml_src;
  logic                wv;
  logic [OFFSET_W-1:0] wo;
  logic [7:0]          wd;
  status_t             st;
  logic [MLEN_W-1:0]   ml;

  assign q_pop = q_valid && (!ov_r || out_ch.ready);

  assign is_first = (tok.kind == cfg.first_code);
  assign is_sub   = (tok.kind == cfg.subseq_code);
  assign is_ctrl  = (tok.kind == cfg.control_code);
  assign sub_ok   = busy_r && (tok.trans == at_r) && (tok.seq == ns_r);
  assign rc_sum   = CMP_W'(rc_r) + CMP_W'(tok.count);
  assign tot_ext  = CMP_W'(tok.total);
  assign ns_inc   = ns_r + 8'd1;

  // Acceptance forecast at header completion
  always_comb begin
    priority if (!tok.fits) begin
      pred = 1'b0;
    end else if (is_ctrl) begin
      pred = 1'b0;
    end else if (is_first) begin
      pred = (tot_ext <= BUF_K);
    end else if (is_sub) begin
      pred = sub_ok && (rc_sum <= BUF_K);
    end else begin
      pred = 1'b0;
    end
  end

  // Staged payload write
  assign base = is_first ? '0 : SUM_W'(rc_r);
  assign wsum = base + SUM_W'(tok.idx);
  assign wv   = tok.pay && pa_r;
  assign wo   = wv ? wsum[OFFSET_W-1:0] : '0;
  assign wd   = wv ? tok.data : '0;

  // End-of-packet update
  always_comb begin
    busy_nxt = busy_r;
    at_nxt   = at_r;
    atot_nxt = atot_r;
    ns_nxt   = ns_r;
    rc_nxt   = rc_r;
    st       = ST_NONE;
    if (tok.last) begin
      priority if (!tok.whole) begin
        st = ST_MALFORMED;
      end else if (is_ctrl) begin
        st = ST_IGNORED;
      end else if (is_first) begin
        if (tot_ext > BUF_K) begin
          busy_nxt = 1'b0;
          at_nxt   = '0;
          atot_nxt = '0;
          ns_nxt   = '0;
          rc_nxt   = '0;
          st       = ST_OVERFLOW;
        end else begin
          at_nxt   = tok.trans;
          atot_nxt = tok.total;
          ns_nxt   = 8'd1;
          rc_nxt   = RC_W'(tok.count);
          if (CMP_W'(tok.count) >= tot_ext) begin
            busy_nxt = 1'b0;
            st       = ST_COMPLETE;
          end else begin
            busy_nxt = 1'b1;
            st       = ST_MORE;
          end
        end
      end else if (is_sub) begin
        if (!sub_ok || rc_sum > BUF_K || ns_inc == 8'd0) begin
          busy_nxt = 1'b0;
          at_nxt   = '0;
          atot_nxt = '0;
          ns_nxt   = '0;
          rc_nxt   = '0;
          st       = (sub_ok && rc_sum > BUF_K) ? ST_OVERFLOW : ST_SEQ_ERR;
        end else begin
          rc_nxt = RC_W'(rc_sum);
          ns_nxt = ns_inc;
          if (rc_sum >= CMP_W'(atot_r)) begin
            busy_nxt = 1'b0;
            st       = ST_COMPLETE;
          end else begin
            st = ST_MORE;
          end
        end
      end else begin
        st = ST_IGNORED;
      end
    end
  end

  assign ml_src = SUM_W'(rc_nxt);
  assign ml     = (st == ST_COMPLETE) ? ml_src[MLEN_W-1:0] : '0;

  // Payload acceptance flag of the packet in flight
  assign pa_nxt = tok.last ? 1'b0 : (tok.hdr_done ? pred : pa_r);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r   <= 1'b0;
      busy_r <= 1'b0;
      at_r   <= '0;
      atot_r <= '0;
      ns_r   <= '0;
      rc_r   <= '0;
    end else if (q_pop) begin
      pa_r   <= pa_nxt;
      busy_r <= busy_nxt;
      at_r   <= at_nxt;
      atot_r <= atot_nxt;
      ns_r   <= ns_nxt;
      rc_r   <= rc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_pop) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wv_r  <= wv;
      wo_r  <= wo;
      wd_r  <= wd;
      st_r  <= st;
      ml_r  <= ml;
      cmd_r <= tok.cmd;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.write_valid     = wv_r;
  assign out_ch.write_offset    = wo_r;
  assign out_ch.write_data      = wd_r;
  assign out_ch.end_status      = st_r;
  assign out_ch.message_length  = ml_r;
  assign out_ch.control_command = cmd_r;

endmodule

/* hdl/container_deframe_reassemble_unit.sv */
// Container deframer / reassembler, top level.
// Depends on cdr_pkg, cdr_chan_if, cdr_front, cdr_queue and cdr_back.
//
// Takes one packet byte per cycle while results are taken, and returns one
// result word per byte, in order. A byte passes the header parser, waits in a
// four-word queue and is resolved by the back end, which owns the reassembly
// state; its result is then held in the output register until taken. The
// sustained rate is one byte per cycle while the result side does not stall,
// set by the back end's end-of-packet update, which is combinational and
// resolves each popped word. The queue plus the output register hold up to five
// words, so input keeps flowing for that many bytes while the result side
// stalls. Configuration writes take effect at the next cycle and are meant for
// times when no packet is in flight. Payload writes are staged: commit them only
// when the packet's end status is "more needed" or "complete".
module container_deframe_reassemble_unit import cdr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdr_in_if.sink                in_ch,
  cdr_out_if.source             out_ch
);

  cfg_t cfg_r;
  logic q_ready, push, q_valid, q_pop;
  tok_t push_tok, pop_tok;

  // Type code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_code   <= 2'd0;
      cfg_r.subseq_code  <= 2'd1;
      cfg_r.control_code <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FIRST:   cfg_r.first_code   <= cfg_data;
        CFG_SUBSEQ:  cfg_r.subseq_code  <= cfg_data;
        CFG_CONTROL: cfg_r.control_code <= cfg_data;
        default: ;
      endcase
    end
  end

  cdr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push),
    .tok     (push_tok)
  );

  cdr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_tok),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_tok)
  );

  cdr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .tok     (pop_tok),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* hdl/cdr_checker.sv */
// Port-level checks for the container deframer / reassembler, bound to the top.
// Depends on cdr_pkg; sees only the top level's channel ports.
module cdr_checker import cdr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_wv,
  input logic [OFFSET_W-1:0] out_wo,
  input logic [7:0]          out_wd,
  input logic [2:0]          out_status,
  input logic [MLEN_W-1:0]   out_ml,
  input logic [3:0]          out_cmd
);

  localparam int unsigned PEND_W = $clog2(Q_DEPTH + 2) + 1;

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_r, pend_last_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words taken but not yet answered, and packet ends among them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pend_last_r <= '0;
    end else begin
      pend_r      <= pend_r + PEND_W'(in_acc) - PEND_W'(out_acc);
      pend_last_r <= pend_last_r + PEND_W'(in_acc && in_last)
                   - PEND_W'(out_acc && (out_status != ST_NONE));
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wv) && $stable(out_wo) &&
      $stable(out_wd) && $stable(out_status) && $stable(out_ml) && $stable(out_cmd))
    else $error("result changed while stalled");

  // No result without a byte behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted byte");

  // An end status answers a byte that ended a packet
  a_end_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_NONE) |-> pend_last_r != '0)
    else $error("end status without a packet end");

  // In-flight words never exceed queue plus output register
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(Q_DEPTH + 1))
    else $error("too many words in flight");

endmodule

bind container_deframe_reassemble_unit cdr_checker u_cdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_byte),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_wv     (out_ch.write_valid),
  .out_wo     (out_ch.write_offset),
  .out_wd     (out_ch.write_data),
  .out_status (out_ch.end_status),
  .out_ml     (out_ch.message_length),
  .out_cmd    (out_ch.control_command)
);
